FILE: hw/rtl/sorted_frequency_table_top_defines.svh
// assertion macros for the sorted frequency table checker
`ifndef SORTED_FREQUENCY_TABLE_TOP_DEFINES_SVH
`define SORTED_FREQUENCY_TABLE_TOP_DEFINES_SVH

// same-cycle implication, sampled on the block clock
`define SFT_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sorted frequency table check failed");

// next-cycle implication, sampled on the block clock
`define SFT_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorted frequency table check failed");

`endif

FILE: hw/rtl/sft_pkg.sv
// shared types and codes for the sorted frequency table
package sft_pkg;

   localparam int CAPACITY  = 64;
   localparam int FREQ_BITS = 40;

   localparam int CMD_W    = 3;
   localparam int FIELD_FW = FREQ_BITS;
   localparam int POS_W    = $clog2(CAPACITY);
   localparam int CNTF_W   = $clog2(CAPACITY + 1);
   localparam int STATUS_W = 2;
   localparam int GEN_W    = 32;

   localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_UPDATE  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RANGE   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_NEAREST = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [FIELD_FW-1:0] freq_hz;
      logic [FIELD_FW-1:0] range_top_hz;
      logic                favourite;
      logic [POS_W-1:0]    position;
      logic [CNTF_W-1:0]   max_count;
      logic [CNTF_W-1:0]   max_favourites;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CNTF_W-1:0]   result_index;
      logic [CNTF_W-1:0]   range_end;
      logic                valid_res;
      logic                last;
      logic [CNTF_W-1:0]   entry_total;
      logic [GEN_W-1:0]    generation;
   } rsp_type;

   typedef struct packed {
      logic ins;
      logic del;
   } ctl_type;

endpackage

FILE: hw/rtl/sorted_frequency_table_top.sv
// sorted frequency table: chain of slot cells plus the command sequencer
// Usage: drive req_data and raise start; the command is taken at a clock edge where
// start is high and busy is low. busy stays high until the command's last result.
// Each result shows on rsp_data for one cycle with rsp_strobe high; the receiver
// cannot stall, so every result must be taken in the cycle it appears.
// Insert and remove shift all cells of the chain in parallel; the position
// search steps one slot a cycle over the cells' compare flags.
// Command steps: remove shifts the chain down; insert searches the position, then
//   shifts up; update removes, then inserts; range searches for each bound.
//   nearest: favourite pass, lower-bound search, outward walk with a registered
//   slot read per step, then one slot per cycle while chosen indices are emitted;
//   when all entries fit, only the emit pass runs.
//   bad position, full table and unknown commands are answered in the next cycle.
// One command is worked on at a time; the next may start in the cycle of the last
// result. Reset empties the table and clears the generation count; slot contents
// are not cleared, only slots below the entry count are ever used.
module sorted_frequency_table_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sft_pkg::req_type req_data,
   output logic             rsp_strobe,
   output sft_pkg::rsp_type rsp_data
);
   import sft_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int MW    = (CNT_W > CNTF_W) ? CNT_W : CNTF_W;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SCAN = 4'd1;
   localparam logic [3:0] S_INS  = 4'd2;
   localparam logic [3:0] S_DEL  = 4'd3;
   localparam logic [3:0] S_FAV  = 4'd4;
   localparam logic [3:0] S_WRD  = 4'd5;
   localparam logic [3:0] S_WDO  = 4'd6;
   localparam logic [3:0] S_EMIT = 4'd7;

   logic [3:0]           state_ff, state_in;
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [FREQ_BITS-1:0] key_ff, key_in;
   logic [FREQ_BITS-1:0] top_ff, top_in;
   logic                 nfav_ff, nfav_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [CNTF_W-1:0]    mc_ff, mc_in;
   logic [CNTF_W-1:0]    mf_ff, mf_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic [GEN_W-1:0]     gen_ff, gen_in;
   logic [CNT_W-1:0]     p_ff, p_in;
   logic [CNT_W-1:0]     lo_ff, lo_in;
   logic [CNT_W-1:0]     hi_ff, hi_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]     k_ff, k_in;
   logic [CAPACITY-1:0]  chosen_ff, chosen_in;
   logic                 phase_ff, phase_in;
   logic                 mode_ff, mode_in;
   logic [FREQ_BITS-1:0] fa_ff, fa_in;
   logic [FREQ_BITS-1:0] fb_ff, fb_in;
   logic                 strobe_ff, strobe_in;
   rsp_type              rsp_ff, rsp_in;

   ctl_type              ctl;
   logic [FREQ_BITS-1:0] freq_arr [CAPACITY];
   logic [CAPACITY-1:0]  fav_vec, occ_vec, lt_vec, le_vec, gt_vec;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic [FREQ_BITS-1:0] prev_freq, next_freq;
         logic                 prev_fav, prev_gt, next_fav;
         if (g == 0) begin : g_head
            assign prev_freq = '0;
            assign prev_fav  = 1'b0;
            assign prev_gt   = 1'b0;
         end else begin : g_mid
            assign prev_freq = freq_arr[g-1];
            assign prev_fav  = fav_vec[g-1];
            assign prev_gt   = gt_vec[g-1];
         end
         if (g == CAPACITY - 1) begin : g_tail
            assign next_freq = '0;
            assign next_fav  = 1'b0;
         end else begin : g_body
            assign next_freq = freq_arr[g+1];
            assign next_fav  = fav_vec[g+1];
         end
         sft_cell #(
            .FREQ_BITS (FREQ_BITS),
            .CNT_W     (CNT_W),
            .INDEX     (g)
         ) u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .key       (key_ff),
            .new_fav   (nfav_ff),
            .fill      (fill_ff),
            .pos       (CNT_W'(pos_ff)),
            .prev_freq (prev_freq),
            .prev_fav  (prev_fav),
            .prev_gt   (prev_gt),
            .next_freq (next_freq),
            .next_fav  (next_fav),
            .freq      (freq_arr[g]),
            .fav       (fav_vec[g]),
            .occ       (occ_vec[g]),
            .lt        (lt_vec[g]),
            .le        (le_vec[g]),
            .gt        (gt_vec[g])
         );
      end
   endgenerate

   function automatic rsp_type make_rsp(input logic [STATUS_W-1:0] status,
                                        input logic [CNT_W-1:0] idx,
                                        input logic [CNT_W-1:0] fin,
                                        input logic valid, input logic last);
      rsp_type r;
      r              = '0;
      r.status       = status;
      r.result_index = CNTF_W'(idx);
      r.range_end    = CNTF_W'(fin);
      r.valid_res    = valid;
      r.last         = last;
      return r;
   endfunction

   logic [IDX_W-1:0]  pidx, loidx, hiidx, jidx;
   logic [CNT_W-1:0]  lo_m1;
   logic              p_lt_fill, mark, take_lo, emit_last;
   logic [CNTF_W-1:0] cap;

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      key_in    = key_ff;
      top_in    = top_ff;
      nfav_in   = nfav_ff;
      pos_in    = pos_ff;
      mc_in     = mc_ff;
      mf_in     = mf_ff;
      fill_in   = fill_ff;
      gen_in    = gen_ff;
      p_in      = p_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      cnt_in    = cnt_ff;
      k_in      = k_ff;
      chosen_in = chosen_ff;
      phase_in  = phase_ff;
      mode_in   = mode_ff;
      fa_in     = fa_ff;
      fb_in     = fb_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      ctl       = '0;

      pidx      = p_ff[IDX_W-1:0];
      lo_m1     = lo_ff - CNT_W'(1);
      loidx     = lo_m1[IDX_W-1:0];
      hiidx     = hi_ff[IDX_W-1:0];
      p_lt_fill = p_ff < fill_ff;
      mark      = mode_ff ? le_vec[pidx] : lt_vec[pidx];
      cap       = (mf_ff < mc_ff) ? mf_ff : mc_ff;
      take_lo   = (lo_ff != '0) && ((hi_ff >= fill_ff) || ((key_ff - fa_ff) <= (fb_ff - key_ff)));
      jidx      = take_lo ? loidx : hiidx;
      emit_last = (k_ff + CNT_W'(1)) == cnt_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in   = req_data.cmd;
               key_in   = FREQ_BITS'(req_data.freq_hz);
               top_in   = FREQ_BITS'(req_data.range_top_hz);
               nfav_in  = req_data.favourite;
               pos_in   = req_data.position;
               mc_in    = req_data.max_count;
               mf_in    = req_data.max_favourites;
               p_in     = '0;
               phase_in = 1'b0;
               case (req_data.cmd)
                  CMD_INSERT: begin
                     if (fill_ff >= CNT_W'(CAPACITY)) begin
                        strobe_in = 1'b1;
                        rsp_in    = make_rsp(STATUS_FULL, '0, '0, 1'b0, 1'b1);
                     end else begin
                        mode_in  = 1'b1;
                        state_in = S_SCAN;
                     end
                  end
                  CMD_REMOVE, CMD_UPDATE: begin
                     if (MW'(req_data.position) >= MW'(fill_ff)) begin
                        strobe_in = 1'b1;
                        rsp_in    = make_rsp(STATUS_RANGE, '0, '0, 1'b0, 1'b1);
                     end else begin
                        state_in = S_DEL;
                     end
                  end
                  CMD_RANGE: begin
                     mode_in  = 1'b0;
                     state_in = S_SCAN;
                  end
                  CMD_NEAREST: begin
                     k_in = '0;
                     if (MW'(fill_ff) <= MW'(req_data.max_count)) begin
                        chosen_in = occ_vec;
                        cnt_in    = fill_ff;
                        state_in  = S_EMIT;
                     end else begin
                        chosen_in = '0;
                        cnt_in    = '0;
                        state_in  = S_FAV;
                     end
                  end
                  default: begin
                     strobe_in = 1'b1;
                     rsp_in    = make_rsp(STATUS_OK, '0, '0, 1'b0, 1'b1);
                  end
               endcase
            end
         end
         S_SCAN: begin
            // step over slots whose flag is set; p stops at the bound
            if (p_lt_fill && mark) begin
               p_in = p_ff + CNT_W'(1);
            end else begin
               case (cmd_ff)
                  CMD_INSERT, CMD_UPDATE: state_in = S_INS;
                  CMD_RANGE: begin
                     if (!phase_ff) begin
                        lo_in    = p_ff;
                        key_in   = top_ff;
                        mode_in  = 1'b1;
                        phase_in = 1'b1;
                     end else begin
                        strobe_in = 1'b1;
                        rsp_in    = make_rsp(STATUS_OK, lo_ff, p_ff, 1'b1, 1'b1);
                        state_in  = S_IDLE;
                     end
                  end
                  CMD_NEAREST: begin
                     lo_in    = p_ff;
                     hi_in    = p_ff;
                     state_in = S_WRD;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_INS: begin
            ctl.ins   = 1'b1;
            fill_in   = fill_ff + CNT_W'(1);
            gen_in    = gen_ff + GEN_W'(1);
            strobe_in = 1'b1;
            rsp_in    = make_rsp(STATUS_OK, p_ff, '0, 1'b1, 1'b1);
            state_in  = S_IDLE;
         end
         S_DEL: begin
            ctl.del = 1'b1;
            fill_in = fill_ff - CNT_W'(1);
            if (cmd_ff == CMD_REMOVE) begin
               gen_in    = gen_ff + GEN_W'(1);
               strobe_in = 1'b1;
               rsp_in    = make_rsp(STATUS_OK, CNT_W'(pos_ff), '0, 1'b1, 1'b1);
               state_in  = S_IDLE;
            end else begin
               p_in     = '0;
               mode_in  = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_FAV: begin
            if (p_lt_fill && (MW'(cnt_ff) < MW'(cap))) begin
               if (fav_vec[pidx]) begin
                  chosen_in[pidx] = 1'b1;
                  cnt_in          = cnt_ff + CNT_W'(1);
               end
               p_in = p_ff + CNT_W'(1);
            end else begin
               p_in     = '0;
               mode_in  = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_WRD: begin
            // register both walk neighbors before comparing distances
            if ((MW'(cnt_ff) < MW'(mc_ff)) && ((lo_ff != '0) || (hi_ff < fill_ff))) begin
               fa_in    = freq_arr[loidx];
               fb_in    = freq_arr[hiidx];
               state_in = S_WDO;
            end else begin
               p_in     = '0;
               k_in     = '0;
               state_in = S_EMIT;
            end
         end
         S_WDO: begin
            if (take_lo) lo_in = lo_m1;
            else hi_in = hi_ff + CNT_W'(1);
            if (!chosen_ff[jidx]) begin
               chosen_in[jidx] = 1'b1;
               cnt_in          = cnt_ff + CNT_W'(1);
            end
            state_in = S_WRD;
         end
         S_EMIT: begin
            if (cnt_ff == '0) begin
               strobe_in = 1'b1;
               rsp_in    = make_rsp(STATUS_OK, '0, '0, 1'b0, 1'b1);
               state_in  = S_IDLE;
            end else begin
               if (p_lt_fill && chosen_ff[pidx]) begin
                  strobe_in = 1'b1;
                  rsp_in    = make_rsp(STATUS_OK, p_ff, '0, 1'b1, emit_last);
                  k_in      = k_ff + CNT_W'(1);
                  if (emit_last) state_in = S_IDLE;
               end
               p_in = p_ff + CNT_W'(1);
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (strobe_in) begin
         rsp_in.entry_total = CNTF_W'(fill_in);
         rsp_in.generation  = gen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         fill_ff   <= '0;
         gen_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         gen_ff    <= gen_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      top_ff    <= top_in;
      nfav_ff   <= nfav_in;
      pos_ff    <= pos_in;
      mc_ff     <= mc_in;
      mf_ff     <= mf_in;
      p_ff      <= p_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      cnt_ff    <= cnt_in;
      k_ff      <= k_in;
      chosen_ff <= chosen_in;
      phase_ff  <= phase_in;
      mode_ff   <= mode_in;
      fa_ff     <= fa_in;
      fb_ff     <= fb_in;
      rsp_ff    <= rsp_in;
   end

endmodule

FILE: hw/rtl/sft_cell.sv
// one table slot: holds an entry, compares it with the key, shifts with its neighbors
module sft_cell #(
   parameter int FREQ_BITS = 40,
   parameter int CNT_W     = 7,
   parameter int INDEX     = 0
) (
   input  logic                 clock,
   input  sft_pkg::ctl_type     ctl,
   input  logic [FREQ_BITS-1:0] key,
   input  logic                 new_fav,
   input  logic [CNT_W-1:0]     fill,
   input  logic [CNT_W-1:0]     pos,
   input  logic [FREQ_BITS-1:0] prev_freq,
   input  logic                 prev_fav,
   input  logic                 prev_gt,
   input  logic [FREQ_BITS-1:0] next_freq,
   input  logic                 next_fav,
   output logic [FREQ_BITS-1:0] freq,
   output logic                 fav,
   output logic                 occ,
   output logic                 lt,
   output logic                 le,
   output logic                 gt
);
   import sft_pkg::*;

   logic [FREQ_BITS-1:0] freq_ff, freq_in;
   logic                 fav_ff, fav_in;

   assign occ  = CNT_W'(INDEX) < fill;
   assign lt   = occ && (freq_ff < key);
   assign le   = occ && (freq_ff <= key);
   assign gt   = !le;
   assign freq = freq_ff;
   assign fav  = fav_ff;

   always_comb begin
      freq_in = freq_ff;
      fav_in  = fav_ff;
      if (ctl.ins) begin
         // slots past the insert point move up by one, the first of them takes the key
         if (prev_gt) begin
            freq_in = prev_freq;
            fav_in  = prev_fav;
         end else if (gt) begin
            freq_in = key;
            fav_in  = new_fav;
         end
      end else if (ctl.del) begin
         if (CNT_W'(INDEX) >= pos) begin
            freq_in = next_freq;
            fav_in  = next_fav;
         end
      end
   end

   always_ff @(posedge clock) begin
      freq_ff <= freq_in;
      fav_ff  <= fav_in;
   end

endmodule

FILE: hw/rtl/sft_checker.sv
// port-level checks for the sorted frequency table, bound to the top level
`include "sorted_frequency_table_top_defines.svh"

module sft_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input sft_pkg::rsp_type rsp_data
);
   import sft_pkg::*;

   // an accepted command is either still working or answered next cycle
   `SFT_ASSERT_NXT(a_accept_progress, start && !busy, busy || rsp_strobe)
   // more results of the same command follow only while busy
   `SFT_ASSERT_IMP(a_more_while_busy, rsp_strobe && !rsp_data.last, busy)
   `SFT_ASSERT_IMP(a_empty_is_last, rsp_strobe && !rsp_data.valid_res, rsp_data.last)
   `SFT_ASSERT_IMP(a_error_no_index, rsp_strobe && (rsp_data.status != STATUS_OK),
                   !rsp_data.valid_res && rsp_data.last)

endmodule

bind sorted_frequency_table_top sft_checker u_sft_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

FILE: dv/tb_top.sv
// self-checking testbench for the sorted frequency table: predictor, scoreboard, stimulus
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sft_pkg::*;

   localparam int DEPTH = 64;
   localparam int STALL_LIMIT = 20000;

   // scoreboard: keeps a shadow table and the queue of predicted results
   class table_scoreboard;
      logic [FIELD_FW-1:0] shadow_freq[DEPTH];
      logic                shadow_fav[DEPTH];
      int unsigned         shadow_fill;
      logic [GEN_W-1:0]    shadow_gen;
      rsp_type             pending_rsp[$];
      int                  error_count;

      function new();
         shadow_fill = 0;
         shadow_gen  = '0;
         error_count = 0;
      endfunction

      function int unsigned first_not_below(logic [FIELD_FW-1:0] f);
         int unsigned i;
         i = 0;
         while (i < shadow_fill && shadow_freq[i] < f) i++;
         return i;
      endfunction

      function int unsigned first_above(logic [FIELD_FW-1:0] f, int unsigned from);
         int unsigned i;
         i = from;
         while (i < shadow_fill && shadow_freq[i] <= f) i++;
         return i;
      endfunction

      function int unsigned place(logic [FIELD_FW-1:0] f, logic fv);
         int unsigned idx;
         idx = first_above(f, 0);
         for (int i = shadow_fill; i > idx; i--) begin
            shadow_freq[i] = shadow_freq[i-1];
            shadow_fav[i]  = shadow_fav[i-1];
         end
         shadow_freq[idx] = f;
         shadow_fav[idx]  = fv;
         shadow_fill++;
         shadow_gen++;
         return idx;
      endfunction

      function void drop(int unsigned p);
         for (int i = p; i + 1 < shadow_fill; i++) begin
            shadow_freq[i] = shadow_freq[i+1];
            shadow_fav[i]  = shadow_fav[i+1];
         end
         shadow_fill--;
      endfunction

      function void push(logic [STATUS_W-1:0] st, int unsigned idx, int unsigned hi,
                         logic vld, logic lst);
         rsp_type r;
         r.status       = st;
         r.result_index = idx[CNTF_W-1:0];
         r.range_end    = hi[CNTF_W-1:0];
         r.valid_res    = vld;
         r.last         = lst;
         r.entry_total  = shadow_fill[CNTF_W-1:0];
         r.generation   = shadow_gen;
         pending_rsp = {pending_rsp, r};
      endfunction

      function void note_request(req_type q);
         bit          chosen[DEPTH];
         int unsigned cnt, lo, hi, cap, k, idx;
         bit          take_lo;
         int unsigned mc, mf;
         mc = q.max_count;
         mf = q.max_favourites;
         cnt = 0;
         k = 0;
         case (q.cmd)
            CMD_INSERT: begin
               if (shadow_fill >= DEPTH) push(STATUS_FULL, 0, 0, 1'b0, 1'b1);
               else begin
                  idx = place(q.freq_hz, q.favourite);
                  push(STATUS_OK, idx, 0, 1'b1, 1'b1);
               end
            end
            CMD_REMOVE, CMD_UPDATE: begin
               if (q.position >= shadow_fill) push(STATUS_RANGE, 0, 0, 1'b0, 1'b1);
               else begin
                  drop(q.position);
                  if (q.cmd == CMD_REMOVE) begin
                     shadow_gen++;
                     push(STATUS_OK, q.position, 0, 1'b1, 1'b1);
                  end else begin
                     idx = place(q.freq_hz, q.favourite);
                     push(STATUS_OK, idx, 0, 1'b1, 1'b1);
                  end
               end
            end
            CMD_RANGE: begin
               lo = first_not_below(q.freq_hz);
               hi = first_above(q.range_top_hz, lo);
               push(STATUS_OK, lo, hi, 1'b1, 1'b1);
            end
            CMD_NEAREST: begin
               foreach (chosen[i]) chosen[i] = 0;
               if (shadow_fill <= mc) begin
                  for (int i = 0; i < shadow_fill; i++) chosen[i] = 1;
                  cnt = shadow_fill;
               end else begin
                  cap = (mf < mc) ? mf : mc;
                  for (int i = 0; i < shadow_fill && cnt < cap; i++)
                     if (shadow_fav[i]) begin
                        chosen[i] = 1;
                        cnt++;
                     end
                  hi = first_not_below(q.freq_hz);
                  lo = hi;
                  while (cnt < mc && (lo > 0 || hi < shadow_fill)) begin
                     take_lo = lo > 0 && (hi >= shadow_fill ||
                        (q.freq_hz - shadow_freq[lo-1]) <= (shadow_freq[hi] - q.freq_hz));
                     if (take_lo) begin
                        lo--;
                        idx = lo;
                     end else begin
                        idx = hi;
                        hi++;
                     end
                     if (!chosen[idx]) begin
                        chosen[idx] = 1;
                        cnt++;
                     end
                  end
               end
               if (cnt == 0) push(STATUS_OK, 0, 0, 1'b0, 1'b1);
               else
                  for (int i = 0; i < shadow_fill; i++)
                     if (chosen[i]) begin
                        k++;
                        push(STATUS_OK, i, 0, 1'b1, k == cnt);
                     end
            end
            default: push(STATUS_OK, 0, 0, 1'b0, 1'b1);
         endcase
      endfunction

      task check_result(rsp_type got);
         rsp_type want;
         if (pending_rsp.size() == 0) begin
            report("result with nothing expected", got, got);
            return;
         end
         want = pending_rsp.pop_front();
         if (got.status !== want.status) report("status", got, want);
         if (got.result_index !== want.result_index) report("result_index", got, want);
         if (got.range_end !== want.range_end) report("range_end", got, want);
         if (got.valid_res !== want.valid_res) report("valid_res", got, want);
         if (got.last !== want.last) report("last", got, want);
         if (got.entry_total !== want.entry_total) report("entry_total", got, want);
         if (got.generation !== want.generation) report("generation", got, want);
      endtask

      task report(string what, rsp_type got, rsp_type want);
         error_count++;
         $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
      endtask
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   table_scoreboard scb = new();
   int sender_idle_pct = 38;
   int idle_cycles = 0;

   always #2 clock = ~clock;

   sorted_frequency_table_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) scb.check_result(rsp_data);
         if ((start && !busy) || rsp_strobe) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("[sorted_frequency_table_top] ERROR");
            $finish;
         end
      end
   end

   // one command transfer; start stays up through back-to-back items
   task automatic send_cmd(req_type q);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      req_data <= q;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      scb.note_request(q);
   endtask

   // frequencies cluster so that ties and duplicates are common
   function automatic logic [FIELD_FW-1:0] pick_freq();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         2: return FIELD_FW'({$urandom, $urandom});
         default: return 40'd1000 + 40'($urandom_range(40));
      endcase
   endfunction

   function automatic req_type rand_req(bit noise);
      req_type q;
      int r;
      q.freq_hz        = pick_freq();
      q.range_top_hz   = pick_freq();
      q.favourite      = $urandom_range(3) == 0;
      q.max_count      = 7'($urandom_range(64));
      q.max_favourites = 7'($urandom_range(64));
      if ($urandom_range(3) == 0) q.max_count = 7'($urandom_range(8));
      r = $urandom_range(99);
      if (noise) q.cmd = 3'($urandom_range(5, 7));
      else if (scb.shadow_fill < 40 && r < 45 || r < 25) q.cmd = CMD_INSERT;
      else if (r < 60) q.cmd = CMD_REMOVE;
      else if (r < 70) q.cmd = CMD_UPDATE;
      else if (r < 80) q.cmd = CMD_RANGE;
      else q.cmd = CMD_NEAREST;
      q.position = 6'($urandom_range(scb.shadow_fill > 0 ? scb.shadow_fill : 63));
      if ($urandom_range(9) == 0) q.position = 6'($urandom_range(63));
      return q;
   endfunction

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (scb.pending_rsp.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   initial begin
      req_type q;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: empty-table corners, extremes, nearest special cases, unknown code
      q = '0;
      q.cmd = CMD_REMOVE; send_cmd(q);
      q.cmd = CMD_UPDATE; q.position = '1; send_cmd(q);
      q.cmd = CMD_NEAREST; q.max_count = 0; send_cmd(q);
      q.cmd = CMD_RANGE; q.freq_hz = '1; q.range_top_hz = '0; send_cmd(q);
      q.cmd = 3'd7; send_cmd(q);
      q = '0; q.cmd = CMD_INSERT; q.freq_hz = '1; q.favourite = 1; send_cmd(q);
      q.freq_hz = '0; q.favourite = 0; send_cmd(q);
      q.freq_hz = 40'd500; send_cmd(q); send_cmd(q);
      q.freq_hz = 40'd510; q.favourite = 1; send_cmd(q);
      q.cmd = CMD_NEAREST; q.freq_hz = 40'd505; q.max_count = 2; q.max_favourites = 1;
      send_cmd(q);
      q.max_favourites = 7'd64; q.max_count = 7'd3; send_cmd(q);
      q.max_count = 7'd64; send_cmd(q);
      q.max_count = 0; send_cmd(q);
      q.cmd = CMD_RANGE; q.freq_hz = 40'd500; q.range_top_hz = 40'd510; send_cmd(q);
      q.cmd = CMD_UPDATE; q.position = 2; q.freq_hz = 40'h55_5555_5555; q.favourite = 0;
      send_cmd(q);
      q.cmd = CMD_REMOVE; q.position = 0; send_cmd(q);
      q.position = 6'd63; send_cmd(q);
      // fill to capacity, then try once more
      while (scb.shadow_fill < DEPTH) begin
         q = rand_req(0);
         q.cmd = CMD_INSERT;
         send_cmd(q);
      end
      q.cmd = CMD_INSERT; q.freq_hz = 40'hAA_AAAA_AAAA; send_cmd(q);
      q.cmd = CMD_NEAREST; q.max_count = 7'd63; q.max_favourites = 7'd64; send_cmd(q);
      q.cmd = CMD_REMOVE; q.position = 6'd63; send_cmd(q);
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 83 : 0;
         for (int n = 0; n < 100; n++) begin
            q = rand_req($urandom_range(19) == 0);
            send_cmd(q);
         end
         drain();
      end

      if (scb.error_count == 0 && scb.pending_rsp.size() == 0)
         $display("[sorted_frequency_table_top] OK");
      else
         $display("[sorted_frequency_table_top] ERROR");
      $finish;
   end
endmodule
